// ----- hw/rtl/dtp_pkg.sv -----
// Shared constants, tables and types for the decimal text parser.
// Used by the divider, the sequencer and the top level; depends on nothing.
package dtp_pkg;

  // Number format of the results.
  localparam int FRAC_BITS       = 16;
  localparam int MAX_FRAC_DIGITS = 5;
  localparam int INT_BITS        = 31;

  // Field widths of the two channels.
  localparam int CHAR_W = 8;
  localparam int TYPE_W = 2;
  localparam int COMP_W = 2;
  localparam int VAL_W  = 48;
  localparam int CNT_W  = 16;

  // Decimal mantissa and the dividend that the conversion builds from it.
  localparam int ACC_W = 48;
  localparam int NUM_W = ACC_W + FRAC_BITS;

  // Fraction digit counter; the divisor tables below have eight rows.
  localparam int FD_W = 3;

  // Divisors for each count of kept fraction digits, plain and for colour.
  localparam longint POW10_TAB [8] = '{
    64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000, 64'd10000000
  };
  localparam longint COLOUR_TAB [8] = '{
    64'd255, 64'd2550, 64'd25500, 64'd255000, 64'd2550000, 64'd25500000,
    64'd255000000, 64'd2550000000
  };
  localparam int DIV_W = $clog2(COLOUR_TAB[MAX_FRAC_DIGITS] + 1);

  // Saturation limits.
  localparam logic [ACC_W-1:0] INT_LIM = ACC_W'((64'd1 << INT_BITS) - 64'd1);
  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [COMP_W-1:0] LAST_COMP = COMP_W'(2);

  // Characters with a meaning of their own.
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'd44;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'd46;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;

  // Field kinds selected when a field starts.
  localparam logic [TYPE_W-1:0] MODE_COORD  = 2'd0;
  localparam logic [TYPE_W-1:0] MODE_COLOUR = 2'd1;
  localparam logic [TYPE_W-1:0] MODE_FLAG   = 2'd2;

  // One result beat as it leaves the sequencer.
  typedef struct packed {
    logic [COMP_W-1:0] component;
    logic [VAL_W-1:0]  value;
    logic              last;
    logic [CNT_W-1:0]  used_count;
  } res_t;

endpackage

// ----- hw/rtl/dtp_divider.sv -----
// Iterative restoring divider that turns a decimal mantissa into fixed point.
// Depends on dtp_pkg; one quotient bit per cycle.
module dtp_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [dtp_pkg::ACC_W-1:0]  acc,
  input  logic [dtp_pkg::DIV_W-1:0]  den,
  output logic                       done,
  output logic [dtp_pkg::NUM_W-1:0]  quotient
);
  import dtp_pkg::*;

  localparam int STEP_W = $clog2(NUM_W);

  logic              busy;
  logic              done_r;
  logic [STEP_W-1:0] step;
  logic [DIV_W-1:0]  den_r;
  logic [DIV_W-1:0]  rem;
  logic [NUM_W-1:0]  qn;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              fits;

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign trial = {rem, qn[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = (trial >= {1'b0, den_r});

  // Control: run for one step per dividend bit, then flag the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == STEP_W'(NUM_W - 1)) begin
        busy   <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath: the dividend is mantissa times 2^FRAC_BITS plus half the
  // divisor, which rounds to nearest; quotient bits replace it from the right.
  always_ff @(posedge clk) begin
    if (start) begin
      step  <= '0;
      rem   <= '0;
      den_r <= den;
      qn    <= {acc, {FRAC_BITS{1'b0}}} + NUM_W'(den >> 1);
    end else if (busy) begin
      step <= step + 1'b1;
      qn   <= {qn[NUM_W-2:0], fits};
      rem  <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = qn;

endmodule

// ----- hw/rtl/dtp_sequencer.sv -----
// Parse sequencer: holds field state, walks one parse step per cycle unless
// stalled; drives the shared divider, hands out result beats; uses dtp_pkg.
module dtp_sequencer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [dtp_pkg::CHAR_W-1:0]  char_code,
  input  logic                        start_req,
  input  logic [dtp_pkg::TYPE_W-1:0]  req_type,
  output logic                        busy,
  output logic                        div_start,
  output logic [dtp_pkg::ACC_W-1:0]   div_acc,
  output logic [dtp_pkg::DIV_W-1:0]   div_den,
  input  logic                        div_done,
  input  logic [dtp_pkg::NUM_W-1:0]   div_quotient,
  output logic                        emit_valid,
  output dtp_pkg::res_t               emit_res,
  input  logic                        emit_take
);
  import dtp_pkg::*;

  typedef enum logic [3:0] {
    SEQ_IDLE = 4'b0001,
    SEQ_STEP = 4'b0010,
    SEQ_DIV  = 4'b0100,
    SEQ_EMIT = 4'b1000
  } seq_t;

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_PRE   = 7'b0000010,
    PH_LEAD  = 7'b0000100,
    PH_SPACE = 7'b0001000,
    PH_INT   = 7'b0010000,
    PH_FRAC  = 7'b0100000,
    PH_FLAG  = 7'b1000000
  } phase_t;

  seq_t               seq, seq_next;
  phase_t             phase, phase_next;
  logic               negative, negative_next;
  logic [ACC_W-1:0]   acc, acc_next;
  logic [FD_W-1:0]    fd, fd_next;
  logic [COMP_W-1:0]  comp, comp_next;
  logic [TYPE_W-1:0]  mode, mode_next;
  logic [CNT_W-1:0]   consumed, consumed_next;
  logic [CHAR_W-1:0]  ch, ch_next;
  logic [VAL_W-1:0]   res_value, res_value_next;
  logic               count_en;
  logic               is_digit;
  logic [ACC_W-1:0]   mul10;
  logic [VAL_W-1:0]   mag;

  // Character classes and the next decimal mantissa (times ten plus digit).
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign mul10    = (acc << 3) + (acc << 1) + ACC_W'(ch[3:0]);

  // Divisor for the digits kept so far, from the constant tables.
  assign div_acc = acc;
  assign div_den = (mode == MODE_COLOUR) ? DIV_W'(COLOUR_TAB[fd]) : DIV_W'(POW10_TAB[fd]);

  // Saturate the quotient to the positive range of the result.
  assign mag = (|div_quotient[NUM_W-1:VAL_W-1]) ? VAL_MAX
             : {1'b0, div_quotient[VAL_W-2:0]};

  // Next state of the sequencer and of the field.
  always_comb begin
    seq_next       = seq;
    phase_next     = phase;
    negative_next  = negative;
    acc_next       = acc;
    fd_next        = fd;
    comp_next      = comp;
    mode_next      = mode;
    consumed_next  = consumed;
    ch_next        = ch;
    res_value_next = res_value;
    count_en       = 1'b0;
    div_start      = 1'b0;

    unique case (seq)
      SEQ_IDLE: begin
        if (accept) begin
          ch_next  = char_code;
          seq_next = SEQ_STEP;
          if (start_req) begin
            mode_next     = req_type;
            negative_next = 1'b0;
            acc_next      = '0;
            fd_next       = '0;
            comp_next     = '0;
            consumed_next = '0;
            priority if (req_type == MODE_COORD || req_type == MODE_COLOUR) begin
              phase_next = PH_PRE;
            end else if (req_type == MODE_FLAG) begin
              phase_next = PH_FLAG;
            end else begin
              phase_next = PH_IDLE;
            end
          end
        end
      end

      SEQ_STEP: begin
        unique case (phase)
          PH_FLAG: begin
            if (ch == CH_SPACE) begin
              count_en = 1'b1;
              seq_next = SEQ_IDLE;
            end else begin
              count_en       = (ch != CH_NUL);
              res_value_next = VAL_W'(ch) - VAL_W'(CH_ZERO);
              seq_next       = SEQ_EMIT;
            end
          end
          PH_PRE: begin
            if (ch == CH_SPACE) begin
              count_en = 1'b1;
              seq_next = SEQ_IDLE;
            end else begin
              phase_next = PH_LEAD;
            end
          end
          PH_LEAD: begin
            phase_next = PH_SPACE;
            if (ch == CH_COMMA) begin
              count_en = 1'b1;
              seq_next = SEQ_IDLE;
            end
          end
          PH_SPACE: begin
            priority if (ch == CH_SPACE) begin
              count_en = 1'b1;
              seq_next = SEQ_IDLE;
            end else if (ch == CH_MINUS) begin
              negative_next = 1'b1;
              phase_next    = PH_INT;
              count_en      = 1'b1;
              seq_next      = SEQ_IDLE;
            end else if (is_digit) begin
              phase_next = PH_INT;
            end else if (ch == CH_DOT) begin
              phase_next = PH_FRAC;
              count_en   = 1'b1;
              seq_next   = SEQ_IDLE;
            end else begin
              // No digits at all: the number closes as zero.
              phase_next = PH_FRAC;
            end
          end
          PH_INT: begin
            priority if (is_digit) begin
              acc_next = (mul10 > INT_LIM) ? INT_LIM : mul10;
              count_en = 1'b1;
              seq_next = SEQ_IDLE;
            end else if (ch == CH_DOT) begin
              phase_next = PH_FRAC;
              count_en   = 1'b1;
              seq_next   = SEQ_IDLE;
            end else begin
              phase_next = PH_FRAC;
            end
          end
          PH_FRAC: begin
            if (is_digit) begin
              // Digits beyond the kept precision are counted and dropped.
              if (fd < FD_W'(MAX_FRAC_DIGITS)) begin
                acc_next = mul10;
                fd_next  = fd + 1'b1;
              end
              count_en = 1'b1;
              seq_next = SEQ_IDLE;
            end else begin
              div_start = 1'b1;
              seq_next  = SEQ_DIV;
            end
          end
          PH_IDLE: begin
            seq_next = SEQ_IDLE;
          end
          default: begin
            phase_next = PH_IDLE;
            seq_next   = SEQ_IDLE;
          end
        endcase
      end

      SEQ_DIV: begin
        if (div_done) begin
          res_value_next = negative ? (VAL_W'(0) - mag) : mag;
          seq_next       = SEQ_EMIT;
        end
      end

      SEQ_EMIT: begin
        if (emit_take) begin
          if (phase == PH_FLAG) begin
            phase_next = PH_IDLE;
            seq_next   = SEQ_IDLE;
          end else begin
            // The held character is looked at again for the next component.
            negative_next = 1'b0;
            acc_next      = '0;
            fd_next       = '0;
            if (comp >= LAST_COMP) begin
              phase_next = PH_IDLE;
              seq_next   = SEQ_IDLE;
            end else begin
              comp_next  = comp + 1'b1;
              phase_next = PH_LEAD;
              seq_next   = SEQ_STEP;
            end
          end
        end
      end

      default: begin
        seq_next = SEQ_IDLE;
      end
    endcase

    // The character count saturates at its full scale.
    if (count_en && consumed != {CNT_W{1'b1}}) begin
      consumed_next = consumed + 1'b1;
    end
  end

  // Field state and sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      seq      <= SEQ_IDLE;
      phase    <= PH_IDLE;
      negative <= 1'b0;
      acc      <= '0;
      fd       <= '0;
      comp     <= '0;
      mode     <= '0;
      consumed <= '0;
    end else begin
      seq      <= seq_next;
      phase    <= phase_next;
      negative <= negative_next;
      acc      <= acc_next;
      fd       <= fd_next;
      comp     <= comp_next;
      mode     <= mode_next;
      consumed <= consumed_next;
    end
  end

  // Held character and pending result value.
  always_ff @(posedge clk) begin
    ch        <= ch_next;
    res_value <= res_value_next;
  end

  // Result beat offered to the output register.
  assign busy                = (seq != SEQ_IDLE);
  assign emit_valid          = (seq == SEQ_EMIT);
  assign emit_res.component  = comp;
  assign emit_res.value      = res_value;
  assign emit_res.last       = (phase == PH_FLAG) || (comp >= LAST_COMP);
  assign emit_res.used_count = consumed;

endmodule

// ----- hw/rtl/decimal_triple_text_parser_core.sv -----
// Top level of the decimal text parser: character channel, result register.
// Depends on dtp_pkg, dtp_divider and dtp_sequencer.
//
// Characters arrive one beat at a time and the block holds char_stall high
// while it works on one. A character is accepted and then takes one parse
// step per cycle, one to four steps, before the next beat can enter. Each
// number that a character closes then takes these steps: one step loads the
// shared restoring divider, which produces one quotient bit per cycle over
// the 64-bit dividend and then flags the quotient, and the result is handed
// to the output register once that register is free. A second or third
// number closed by the same character first repeats the separator and sign
// steps. A result that finds the output register still held waits there as
// long as the receiver stalls. Results leave through a registered output
// stage, so a finished beat may wait there while the next character is
// taken. Values are signed with 16 fraction bits, rounded to nearest with
// ties away from zero; colour values are divided by 255, and flags give the
// character minus 48.
module decimal_triple_text_parser_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               char_valid,
  output logic                               char_stall,
  input  logic [dtp_pkg::CHAR_W-1:0]         char_code,
  input  logic                               start_req,
  input  logic [dtp_pkg::TYPE_W-1:0]         req_type,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [dtp_pkg::COMP_W-1:0]         component,
  output logic signed [dtp_pkg::VAL_W-1:0]   value,
  output logic                               last,
  output logic [dtp_pkg::CNT_W-1:0]          used_count
);
  import dtp_pkg::*;

  logic              busy;
  logic              accept;
  logic              div_start;
  logic [ACC_W-1:0]  div_acc;
  logic [DIV_W-1:0]  div_den;
  logic              div_done;
  logic [NUM_W-1:0]  div_quotient;
  logic              emit_valid;
  res_t              emit_res;
  logic              emit_take;
  logic              out_free;
  res_t              res_q;

  // Input handshake: a beat enters only while the sequencer is idle.
  assign char_stall = busy;
  assign accept     = char_valid && !busy;

  dtp_sequencer u_seq (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .char_code    (char_code),
    .start_req    (start_req),
    .req_type     (req_type),
    .busy         (busy),
    .div_start    (div_start),
    .div_acc      (div_acc),
    .div_den      (div_den),
    .div_done     (div_done),
    .div_quotient (div_quotient),
    .emit_valid   (emit_valid),
    .emit_res     (emit_res),
    .emit_take    (emit_take)
  );

  dtp_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .acc      (div_acc),
    .den      (div_den),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Output register: loads whenever it is empty or being drained.
  assign out_free  = !result_valid || !result_stall;
  assign emit_take = emit_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_take) begin
      res_q <= emit_res;
    end
  end

  assign component  = res_q.component;
  assign value      = $signed(res_q.value);
  assign last       = res_q.last;
  assign used_count = res_q.used_count;

endmodule
